// ===== hw/rtl/smallest_string_period_top_macros.svh =====
// ============================================================================
// Assertion macros for the smallest string period block
// Concurrent assertion wrappers that compile to nothing when ASSERT_OFF is set.
// ============================================================================
`ifndef SMALLEST_STRING_PERIOD_TOP_MACROS_SVH
`define SMALLEST_STRING_PERIOD_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// The property must hold at every rising clock edge outside reset.
`define SSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The condition must never be seen at a rising clock edge outside reset.
`define SSP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== hw/rtl/ssp_pkg.sv =====
// ============================================================================
// ssp_pkg
// Types and constants shared by the smallest string period block.
// ============================================================================
package ssp_pkg;

    localparam int MAX_LEN_DEF = 128;
    localparam int CHAR_W      = 8;
    localparam int PERIOD_W    = 8;

    typedef enum logic [2:0] {
        S_LOAD,
        S_DIV,
        S_CMP,
        S_NEXT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                overflow;
    } t_result;

endpackage

// ===== hw/rtl/ssp_in_if.sv =====
// ============================================================================
// ssp_in_if
// Input channel: one character per item with a last-character flag.
// ============================================================================
interface ssp_in_if;
    logic                        valid;
    logic                        ready;
    logic [ssp_pkg::CHAR_W-1:0]  char_code;
    logic                        is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ===== hw/rtl/ssp_out_if.sv =====
// ============================================================================
// ssp_out_if
// Output channel: one period result per string.
// ============================================================================
interface ssp_out_if;
    logic                          valid;
    logic                          ready;
    logic [ssp_pkg::PERIOD_W-1:0]  period;
    logic                          overflow;

    modport source (output valid, output period, output overflow, input ready);
    modport sink   (input valid, input period, input overflow, output ready);
endinterface

// ===== hw/rtl/ssp_char_mem.sv =====
// ============================================================================
// ssp_char_mem
// Character store: one write port, two registered read ports.
// ============================================================================
module ssp_char_mem #(
    parameter  int DEPTH  = ssp_pkg::MAX_LEN_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [ssp_pkg::CHAR_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]          i_raddr_a,
    input  logic [ADDR_W-1:0]          i_raddr_b,
    output logic [ssp_pkg::CHAR_W-1:0] o_rdata_a,
    output logic [ssp_pkg::CHAR_W-1:0] o_rdata_b
);

    logic [ssp_pkg::CHAR_W-1:0] r_mem [DEPTH];
    logic [ssp_pkg::CHAR_W-1:0] r_rdata_a;
    logic [ssp_pkg::CHAR_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hw/rtl/ssp_ctrl.sv =====
// ============================================================================
// ssp_ctrl
// Load sequencer and period search engine with its result register.
// ============================================================================
module ssp_ctrl #(
    parameter  int MAX_LEN = ssp_pkg::MAX_LEN_DEF,
    localparam int ADDR_W  = $clog2(MAX_LEN),
    localparam int CNT_W   = $clog2(MAX_LEN + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [ssp_pkg::CHAR_W-1:0] i_in_char,
    input  logic                       i_in_last,
    output logic                       o_in_ready,
    output logic                       o_mem_we,
    output logic [ADDR_W-1:0]          o_mem_waddr,
    output logic [ssp_pkg::CHAR_W-1:0] o_mem_wdata,
    output logic [ADDR_W-1:0]          o_mem_raddr_a,
    output logic [ADDR_W-1:0]          o_mem_raddr_b,
    input  logic [ssp_pkg::CHAR_W-1:0] i_mem_rdata_a,
    input  logic [ssp_pkg::CHAR_W-1:0] i_mem_rdata_b,
    output logic                       o_out_valid,
    output ssp_pkg::t_result           o_out_data,
    input  logic                       i_out_ready
);

    localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    ssp_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_p, n_p;
    logic [CNT_W-1:0] r_r, n_r;
    logic [CNT_W-1:0] r_i, n_i;
    logic             r_cmp_v, n_cmp_v;
    logic             r_cmp_last, n_cmp_last;
    logic             r_out_v, n_out_v;
    ssp_pkg::t_result r_out, n_out;
    logic [CNT_W:0]   w_sum;
    logic [CNT_W-1:0] w_len;
    logic             w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssp_pkg::S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_cmp_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_cmp_v <= n_cmp_v;
            r_out_v <= n_out_v;
        end
        r_n        <= n_n;
        r_p        <= n_p;
        r_r        <= n_r;
        r_i        <= n_i;
        r_cmp_last <= n_cmp_last;
        r_out      <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_n        = r_n;
        n_p        = r_p;
        n_r        = r_r;
        n_i        = r_i;
        n_cmp_v    = r_cmp_v;
        n_cmp_last = r_cmp_last;
        n_out_v    = r_out_v;
        n_out      = r_out;

        w_room = (r_count < LEN_MAX);
        w_len  = w_room ? (r_count + ONE) : r_count;
        w_sum  = {1'b0, r_i} + {1'b0, r_p};

        o_in_ready    = (r_state == ssp_pkg::S_LOAD);
        o_mem_we      = o_in_ready && i_in_valid && w_room;
        o_mem_waddr   = r_count[ADDR_W-1:0];
        o_mem_wdata   = i_in_char;
        o_mem_raddr_a = r_i[ADDR_W-1:0];
        o_mem_raddr_b = w_sum[ADDR_W-1:0];

        if (r_out_v && i_out_ready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            ssp_pkg::S_LOAD: begin
                if (i_in_valid) begin
                    n_count = w_len;
                    if (!w_room) begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_last) begin
                        n_n   = w_len;
                        n_p   = ONE;
                        n_r   = w_len;
                        n_state = (w_len == ONE) ? ssp_pkg::S_DONE : ssp_pkg::S_DIV;
                    end
                end
            end
            ssp_pkg::S_DIV: begin
                // Divisibility by repeated subtraction.
                if (r_r > r_p) begin
                    n_r = r_r - r_p;
                end else if (r_r == r_p) begin
                    n_i     = '0;
                    n_cmp_v = 1'b0;
                    n_state = ssp_pkg::S_CMP;
                end else begin
                    n_state = ssp_pkg::S_NEXT;
                end
            end
            ssp_pkg::S_CMP: begin
                if (r_cmp_v && (i_mem_rdata_a != i_mem_rdata_b)) begin
                    n_cmp_v = 1'b0;
                    n_state = ssp_pkg::S_NEXT;
                end else if (r_cmp_v && r_cmp_last) begin
                    n_cmp_v = 1'b0;
                    n_state = ssp_pkg::S_DONE;
                end else if (w_sum < {1'b0, r_n}) begin
                    n_cmp_v    = 1'b1;
                    n_cmp_last = ((w_sum + 1'b1) == {1'b0, r_n});
                    n_i        = r_i + ONE;
                end else begin
                    n_cmp_v = 1'b0;
                end
            end
            ssp_pkg::S_NEXT: begin
                n_p = r_p + ONE;
                n_r = r_n;
                n_state = ((r_p + ONE) == r_n) ? ssp_pkg::S_DONE : ssp_pkg::S_DIV;
            end
            ssp_pkg::S_DONE: begin
                if (!r_out_v || i_out_ready) begin
                    n_out_v          = 1'b1;
                    n_out.period     = ssp_pkg::PERIOD_W'(r_p);
                    n_out.overflow   = r_ovf;
                    n_count          = '0;
                    n_ovf            = 1'b0;
                    n_state          = ssp_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = ssp_pkg::S_LOAD;
            end
        endcase

        o_out_valid = r_out_v;
        o_out_data  = r_out;
    end

endmodule

// ===== hw/rtl/smallest_string_period_top.sv =====
// ============================================================================
// smallest_string_period_top
// Finds the shortest unit whose repetition forms a string of characters.
// ============================================================================
//
//  Channel   Direction  Payload                 Item
//  i_in      sink       char_code[7:0], is_last one character of the string
//  o_out     source     period[7:0], overflow   one result per string
//
// Each character item is taken and written to the store while there is room;
// later ones are dropped and set the overflow flag. After the last one, each
// length p is tried: a subtraction loop tests whether p divides n, and for a
// divisor a walk compares entries p apart, a pair per cycle. No item is taken
// during the search. Reset is synchronous, active low, and leaves the store
// as it is. A waiting result delays only the next result, not loading.
// ============================================================================
`include "smallest_string_period_top_macros.svh"

module smallest_string_period_top #(
    parameter int MAX_LEN = ssp_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssp_in_if.sink      i_in,
    ssp_out_if.source   o_out
);

    localparam int ADDR_W = $clog2(MAX_LEN);

    logic                       w_mem_we;
    logic [ADDR_W-1:0]          w_mem_waddr;
    logic [ssp_pkg::CHAR_W-1:0] w_mem_wdata;
    logic [ADDR_W-1:0]          w_mem_raddr_a;
    logic [ADDR_W-1:0]          w_mem_raddr_b;
    logic [ssp_pkg::CHAR_W-1:0] w_mem_rdata_a;
    logic [ssp_pkg::CHAR_W-1:0] w_mem_rdata_b;
    ssp_pkg::t_result           w_result;
    logic                       w_last_taken;
    logic                       w_busy;
    logic                       w_zero_period;

    // Character store.
    ssp_char_mem #(
        .DEPTH (MAX_LEN)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_mem_we),
        .i_waddr   (w_mem_waddr),
        .i_wdata   (w_mem_wdata),
        .i_raddr_a (w_mem_raddr_a),
        .i_raddr_b (w_mem_raddr_b),
        .o_rdata_a (w_mem_rdata_a),
        .o_rdata_b (w_mem_rdata_b)
    );

    // Load sequencer, search engine and output register.
    ssp_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_char     (i_in.char_code),
        .i_in_last     (i_in.is_last),
        .o_in_ready    (i_in.ready),
        .o_mem_we      (w_mem_we),
        .o_mem_waddr   (w_mem_waddr),
        .o_mem_wdata   (w_mem_wdata),
        .o_mem_raddr_a (w_mem_raddr_a),
        .o_mem_raddr_b (w_mem_raddr_b),
        .i_mem_rdata_a (w_mem_rdata_a),
        .i_mem_rdata_b (w_mem_rdata_b),
        .o_out_valid   (o_out.valid),
        .o_out_data    (w_result),
        .i_out_ready   (o_out.ready)
    );

    assign o_out.period   = w_result.period;
    assign o_out.overflow = w_result.overflow;

    // Terms for the checks below.
    assign w_last_taken  = i_in.valid && i_in.ready && i_in.is_last;
    assign w_busy        = !i_in.ready;
    assign w_zero_period = o_out.valid && (o_out.period == '0) && (MAX_LEN < 256);

    // Taking the last character of a string always leaves the loading state, so the input stalls.
    `SSP_ASSERT(a_last_stalls, i_clk, i_rst_n, w_last_taken |=> !i_in.ready, "no stall after last")

    // A new result only appears at the end of processing a string, after the input has stalled.
    `SSP_ASSERT(a_out_late, i_clk, i_rst_n, $rose(o_out.valid) |-> $past(w_busy), "early result")

    // The period is never zero while it fits in the output field.
    `SSP_ASSERT_NEVER(a_period_nonzero, i_clk, i_rst_n, w_zero_period, "zero period reported")

endmodule
